// File: rtl/core/stxd_pkg.sv
package stxd_pkg;

   localparam logic [7:0] CODE_STX     = 8'h01;
   localparam logic [7:0] CODE_ETX     = 8'h02;
   localparam logic [7:0] CODE_ESC     = 8'h03;
   localparam logic [7:0] CODE_ESC_STX = 8'h11;
   localparam logic [7:0] CODE_ESC_ETX = 8'h12;
   localparam logic [7:0] CODE_ESC_ESC = 8'h13;

   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   // deframer state carried from one transaction to the next
   typedef struct packed {
      logic        frame_open;
      logic        escape_pending;
      logic [15:0] payload_count;
   } state_type;

   // one result transaction
   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic [15:0] out_index;
      logic        frame_end;
      logic        frame_ok;
      logic [15:0] frame_length;
      logic        frame_abort;
      logic        in_frame;
   } result_type;

endpackage

// File: rtl/core/stxd_req_if.sv
interface stxd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// File: rtl/core/stxd_rsp_if.sv
interface stxd_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_valid;
   logic [7:0]  out_byte;
   logic [15:0] out_index;
   logic        frame_end;
   logic        frame_ok;
   logic [15:0] frame_length;
   logic        frame_abort;
   logic        in_frame;

   modport source (output valid, output out_valid, output out_byte, output out_index,
                   output frame_end, output frame_ok, output frame_length,
                   output frame_abort, output in_frame, input ready);
   modport sink (input valid, input out_valid, input out_byte, input out_index,
                 input frame_end, input frame_ok, input frame_length,
                 input frame_abort, input in_frame, output ready);
endinterface

// File: rtl/core/stxd_decode.sv
module stxd_decode
   import stxd_pkg::*;
(
   input  logic [7:0]  in_byte,
   input  logic [15:0] capacity,
   input  state_type   cur_state,
   output state_type   next_state,
   output result_type  result
);

   logic       do_emit;
   logic [7:0] emit_byte;
   logic       bad_escape;

   // classify the byte against the current state
   always_comb begin
      next_state = cur_state;
      do_emit    = 1'b0;
      emit_byte  = in_byte;
      bad_escape = 1'b0;
      result     = '0;
      if (in_byte == CODE_STX) begin
         next_state.frame_open     = 1'b1;
         next_state.escape_pending = 1'b0;
         next_state.payload_count  = '0;
      end else if (cur_state.frame_open) begin
         if (in_byte == CODE_ETX) begin
            result.frame_end          = 1'b1;
            result.frame_ok           = ~cur_state.escape_pending;
            result.frame_length       = cur_state.payload_count;
            next_state.frame_open     = 1'b0;
            next_state.escape_pending = 1'b0;
         end else if (cur_state.escape_pending) begin
            next_state.escape_pending = 1'b0;
            case (in_byte)
               CODE_ESC_STX: begin
                  do_emit   = 1'b1;
                  emit_byte = CODE_STX;
               end
               CODE_ESC_ETX: begin
                  do_emit   = 1'b1;
                  emit_byte = CODE_ETX;
               end
               CODE_ESC_ESC: begin
                  do_emit   = 1'b1;
                  emit_byte = CODE_ESC;
               end
               default: bad_escape = 1'b1;
            endcase
         end else if (in_byte == CODE_ESC) begin
            next_state.escape_pending = 1'b1;
         end else begin
            do_emit = 1'b1;
         end
      end

      // overflow aborts just like a bad escape
      if (bad_escape || (do_emit && (cur_state.payload_count >= capacity))) begin
         next_state.frame_open     = 1'b0;
         next_state.escape_pending = 1'b0;
         next_state.payload_count  = '0;
         result.frame_abort        = 1'b1;
      end else if (do_emit) begin
         result.out_valid         = 1'b1;
         result.out_byte          = emit_byte;
         result.out_index         = cur_state.payload_count;
         next_state.payload_count = cur_state.payload_count + 16'd1;
      end

      result.in_frame = next_state.frame_open;
   end

endmodule

// File: rtl/core/stx_etx_byte_stuff_decoder_top.sv
// STX/ETX deframer with ESC byte stuffing. Each req transaction carries one raw
// link byte; each produces exactly one rsp transaction describing what that byte
// did: a decoded payload byte with its index, a frame close (with good/bad status
// and length), an abort (overflow past the capacity register or an invalid
// escape code), and whether a frame is open afterwards. Bytes outside a frame
// give an all-zero result apart from in_frame. Throughput is one transaction
// per clock while the response side accepts; a transaction passes through an
// input register followed by a result register. The frame state (open, escape
// pending, payload count) is updated once per transaction as it leaves the
// input register, which sets that one-per-clock rate. The capacity register
// resets to 4096 and should be written only while no transaction is in flight.
module stx_etx_byte_stuff_decoder_top
   import stxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   stxd_req_if.sink    req_chan,
   stxd_rsp_if.source  rsp_chan
);

   // capacity register
   logic [15:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_free;    // result register can take a new transaction
   logic       advance;     // input stage moves into result stage

   assign out_free       = ~rsp_chan.valid | rsp_chan.ready;
   assign advance        = in_valid_ff & out_free;
   assign req_chan.ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
      end
   end

   // frame state, committed when a transaction leaves the input stage
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;

   stxd_decode u_decode (
      .in_byte    (in_byte_ff),
      .capacity   (capacity_ff),
      .cur_state  (state_ff),
      .next_state (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result stage
   logic       rsp_valid_ff;
   result_type result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_valid    = result_ff.out_valid;
   assign rsp_chan.out_byte     = result_ff.out_byte;
   assign rsp_chan.out_index    = result_ff.out_index;
   assign rsp_chan.frame_end    = result_ff.frame_end;
   assign rsp_chan.frame_ok     = result_ff.frame_ok;
   assign rsp_chan.frame_length = result_ff.frame_length;
   assign rsp_chan.frame_abort  = result_ff.frame_abort;
   assign rsp_chan.in_frame     = result_ff.in_frame;

   // an escape can only be pending inside an open frame
   a_esc_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape_pending |-> state_ff.frame_open)
      else $error("escape pending with no open frame");

   // an abort always leaves the frame closed
   a_abort_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_abort) |-> !rsp_chan.in_frame)
      else $error("abort reported with frame still open");

   // a byte, a close and an abort are mutually exclusive
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         $onehot0({rsp_chan.out_valid, rsp_chan.frame_end, rsp_chan.frame_abort}))
      else $error("more than one event in one transaction");

   // frame_ok only accompanies frame_end, and a close leaves no frame open
   a_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.frame_ok || rsp_chan.frame_end)) |->
         (rsp_chan.frame_end && !rsp_chan.in_frame))
      else $error("inconsistent frame end flags");

endmodule
